// ===== rtl/famr_pkg.sv =====
package famr_pkg;

    localparam int STATUS_W = 2;
    localparam int NUM_OUT_W = 33;
    localparam int DEN_OUT_W = 32;
    localparam int EXT_W = 64;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_DEN_ZERO = 2'd1,
        ST_NUM_ZERO = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        MS_AN_BD = 2'd0,
        MS_BN_AD = 2'd1,
        MS_AD_BD = 2'd2,
        MS_AN_BN = 2'd3
    } t_msel;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_CHECK,
        S_GCD,
        S_DIVI,
        S_DIVN,
        S_DIVD,
        S_FIN
    } t_state;

    typedef struct packed {
        logic  load;
        t_msel mul_sel;
        logic  num_set;
        logic  num_add;
        logic  den_set;
        logic  gcd_init;
        logic  gcd_step;
        logic  div_init;
        logic  div_den;
        logic  div_step;
        logic  qn_save;
        logic  out_load;
    } t_cmd;

    typedef struct packed {
        logic mode;
        logic den_zero;
        logic num_zero;
        logic gcd_done;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

// ===== rtl/famr_if.sv =====
interface famr_in_if #(
    parameter int W = 16
);
    logic                valid;
    logic                ready;
    logic                mode;
    logic signed [W-1:0] a_num;
    logic signed [W-1:0] a_den;
    logic signed [W-1:0] b_num;
    logic signed [W-1:0] b_den;

    modport source (output valid, mode, a_num, a_den, b_num, b_den, input ready);
    modport sink (input valid, mode, a_num, a_den, b_num, b_den, output ready);
endinterface

interface famr_out_if;
    logic                                 valid;
    logic                                 ready;
    logic [famr_pkg::STATUS_W-1:0]        status;
    logic signed [famr_pkg::NUM_OUT_W-1:0] res_num;
    logic signed [famr_pkg::DEN_OUT_W-1:0] res_den;

    modport source (output valid, status, res_num, res_den, input ready);
    modport sink (input valid, status, res_num, res_den, output ready);
endinterface

// ===== rtl/famr_ctrl.sv =====
module famr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  famr_pkg::t_sts    i_sts,
    output famr_pkg::t_cmd    o_cmd
);

    famr_pkg::t_state r_state;
    famr_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= famr_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_in_ready = 1'b0;
        o_cmd = '0;
        o_cmd.mul_sel = famr_pkg::MS_AN_BD;
        case (r_state)
            famr_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = famr_pkg::S_MUL0;
                end
            end
            famr_pkg::S_MUL0: begin
                o_cmd.mul_sel = i_sts.mode ? famr_pkg::MS_AN_BN : famr_pkg::MS_AN_BD;
                n_state = famr_pkg::S_MUL1;
            end
            famr_pkg::S_MUL1: begin
                o_cmd.num_set = 1'b1;
                o_cmd.mul_sel = famr_pkg::MS_BN_AD;
                n_state = famr_pkg::S_MUL2;
            end
            famr_pkg::S_MUL2: begin
                o_cmd.num_add = !i_sts.mode;
                o_cmd.mul_sel = famr_pkg::MS_AD_BD;
                n_state = famr_pkg::S_MUL3;
            end
            famr_pkg::S_MUL3: begin
                o_cmd.den_set = 1'b1;
                n_state = famr_pkg::S_CHECK;
            end
            famr_pkg::S_CHECK: begin
                if (i_sts.den_zero || i_sts.num_zero) begin
                    n_state = famr_pkg::S_FIN;
                end else begin
                    o_cmd.gcd_init = 1'b1;
                    n_state = famr_pkg::S_GCD;
                end
            end
            famr_pkg::S_GCD: begin
                o_cmd.gcd_step = 1'b1;
                if (i_sts.gcd_done) begin
                    n_state = famr_pkg::S_DIVI;
                end
            end
            famr_pkg::S_DIVI: begin
                o_cmd.div_init = 1'b1;
                n_state = famr_pkg::S_DIVN;
            end
            famr_pkg::S_DIVN: begin
                if (i_sts.div_done) begin
                    o_cmd.qn_save = 1'b1;
                    o_cmd.div_init = 1'b1;
                    o_cmd.div_den = 1'b1;
                    n_state = famr_pkg::S_DIVD;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            famr_pkg::S_DIVD: begin
                if (i_sts.div_done) begin
                    n_state = famr_pkg::S_FIN;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            famr_pkg::S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = famr_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = famr_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/famr_dp.sv =====
module famr_dp #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  famr_pkg::t_cmd                         i_cmd,
    output famr_pkg::t_sts                         o_sts,
    input  logic                                   i_mode,
    input  logic signed [OPERAND_WIDTH-1:0]        i_a_num,
    input  logic signed [OPERAND_WIDTH-1:0]        i_a_den,
    input  logic signed [OPERAND_WIDTH-1:0]        i_b_num,
    input  logic signed [OPERAND_WIDTH-1:0]        i_b_den,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic [famr_pkg::STATUS_W-1:0]          o_status,
    output logic signed [famr_pkg::NUM_OUT_W-1:0]  o_res_num,
    output logic signed [famr_pkg::DEN_OUT_W-1:0]  o_res_den
);

    localparam int W = OPERAND_WIDTH;
    localparam int RW = (2 * W + 1 > famr_pkg::EXT_W) ? famr_pkg::EXT_W : 2 * W + 1;
    localparam int CW = $clog2(RW + 1);

    logic                   r_mode;
    logic signed [W-1:0]    r_an;
    logic signed [W-1:0]    r_ad;
    logic signed [W-1:0]    r_bn;
    logic signed [W-1:0]    r_bd;
    logic signed [W-1:0]    w_ma;
    logic signed [W-1:0]    w_mb;
    logic signed [2*W-1:0]  w_prod;
    logic signed [2*W-1:0]  r_prod;
    logic signed [RW-1:0]   r_num;
    logic signed [RW-1:0]   r_den;
    logic [RW-1:0]          w_num_u;
    logic [RW-1:0]          w_den_u;
    logic [RW-1:0]          w_mag_num;
    logic [RW-1:0]          w_mag_den;

    logic [RW-1:0]          r_u;
    logic [RW-1:0]          r_v;
    logic [CW-1:0]          r_k;
    logic [RW-1:0]          r_g;
    logic [RW-1:0]          w_u_minus_v;
    logic [RW-1:0]          w_v_minus_u;
    logic                   w_gcd_done;

    logic [RW-1:0]          r_rem;
    logic [RW-1:0]          r_quo;
    logic [CW-1:0]          r_cnt;
    logic [RW-1:0]          r_qn;
    logic [RW:0]            w_sh;
    logic [RW:0]            w_trial;
    logic                   w_fit;

    logic [RW-1:0]          w_qn_neg;
    logic [RW-1:0]          w_qd_neg;
    logic signed [RW-1:0]   w_qn_s;
    logic signed [RW-1:0]   w_qd_s;
    logic signed [famr_pkg::EXT_W-1:0] w_qn_ext;
    logic signed [famr_pkg::EXT_W-1:0] w_qd_ext;

    logic                                  r_out_valid;
    logic [famr_pkg::STATUS_W-1:0]         r_status;
    logic signed [famr_pkg::NUM_OUT_W-1:0] r_res_num;
    logic signed [famr_pkg::DEN_OUT_W-1:0] r_res_den;

    always_comb begin
        case (i_cmd.mul_sel)
            famr_pkg::MS_AN_BD: begin
                w_ma = r_an;
                w_mb = r_bd;
            end
            famr_pkg::MS_BN_AD: begin
                w_ma = r_bn;
                w_mb = r_ad;
            end
            famr_pkg::MS_AD_BD: begin
                w_ma = r_ad;
                w_mb = r_bd;
            end
            famr_pkg::MS_AN_BN: begin
                w_ma = r_an;
                w_mb = r_bn;
            end
            default: begin
                w_ma = r_an;
                w_mb = r_bd;
            end
        endcase
    end

    assign w_prod = w_ma * w_mb;

    assign w_num_u = r_num;
    assign w_den_u = r_den;
    assign w_mag_num = r_num[RW-1] ? (~w_num_u + RW'(1)) : w_num_u;
    assign w_mag_den = r_den[RW-1] ? (~w_den_u + RW'(1)) : w_den_u;

    assign w_u_minus_v = r_u - r_v;
    assign w_v_minus_u = r_v - r_u;
    assign w_gcd_done = r_u[0] && r_v[0] && (r_u == r_v);

    assign w_sh = {r_rem, r_quo[RW-1]};
    assign w_trial = w_sh - {1'b0, r_g};
    assign w_fit = !w_trial[RW];

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        if (i_cmd.load) begin
            r_mode <= i_mode;
            r_an <= i_a_num;
            r_ad <= i_a_den;
            r_bn <= i_b_num;
            r_bd <= i_b_den;
        end
        if (i_cmd.num_set) begin
            r_num <= RW'(r_prod);
        end else if (i_cmd.num_add) begin
            r_num <= r_num + RW'(r_prod);
        end
        if (i_cmd.den_set) begin
            r_den <= RW'(r_prod);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.gcd_init) begin
            r_u <= w_mag_num;
            r_v <= w_mag_den;
            r_k <= '0;
        end else if (i_cmd.gcd_step) begin
            if (!r_u[0] && !r_v[0]) begin
                r_u <= r_u >> 1;
                r_v <= r_v >> 1;
                r_k <= r_k + CW'(1);
            end else if (!r_u[0]) begin
                r_u <= r_u >> 1;
            end else if (!r_v[0]) begin
                r_v <= r_v >> 1;
            end else if (r_u == r_v) begin
                r_g <= r_u << r_k;
            end else if (r_u > r_v) begin
                r_u <= w_u_minus_v >> 1;
            end else begin
                r_v <= w_v_minus_u >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.qn_save) begin
            r_qn <= r_quo;
        end
        if (i_cmd.div_init) begin
            r_rem <= '0;
            r_quo <= i_cmd.div_den ? w_mag_den : w_mag_num;
            r_cnt <= CW'(RW);
        end else if (i_cmd.div_step) begin
            r_rem <= w_fit ? w_trial[RW-1:0] : w_sh[RW-1:0];
            r_quo <= {r_quo[RW-2:0], w_fit};
            r_cnt <= r_cnt - CW'(1);
        end
    end

    assign w_qn_neg = ~r_qn + RW'(1);
    assign w_qd_neg = ~r_quo + RW'(1);
    assign w_qn_s = r_num[RW-1] ? w_qn_neg : r_qn;
    assign w_qd_s = r_den[RW-1] ? w_qd_neg : r_quo;
    assign w_qn_ext = famr_pkg::EXT_W'(w_qn_s);
    assign w_qd_ext = famr_pkg::EXT_W'(w_qd_s);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (r_den == '0) begin
                r_status <= famr_pkg::ST_DEN_ZERO;
                r_res_num <= '0;
                r_res_den <= '0;
            end else if (r_num == '0) begin
                r_status <= famr_pkg::ST_NUM_ZERO;
                r_res_num <= '0;
                r_res_den <= famr_pkg::DEN_OUT_W'(1);
            end else begin
                r_status <= famr_pkg::ST_OK;
                r_res_num <= w_qn_ext[famr_pkg::NUM_OUT_W-1:0];
                r_res_den <= w_qd_ext[famr_pkg::DEN_OUT_W-1:0];
            end
        end
    end

    assign o_sts.mode = r_mode;
    assign o_sts.den_zero = (r_den == '0);
    assign o_sts.num_zero = (r_num == '0);
    assign o_sts.gcd_done = w_gcd_done;
    assign o_sts.div_done = (r_cnt == '0);
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_status = r_status;
    assign o_res_num = r_res_num;
    assign o_res_den = r_res_den;

endmodule

// ===== rtl/fraction_add_mul_reduce_core.sv =====
// A zero numerator or denominator goes from the check straight to the output register;
// otherwise the binary GCD loop runs on the magnitudes, R = min(2*OPERAND_WIDTH+1, 64) bits,
// and the restoring divider (one quotient bit a cycle) runs twice, dividing each by the GCD.
// Words are taken one at a time: a new word is accepted only while the controller is idle.
// A finished result waits in the output register while the next word is taken.
// Reset (synchronous, active low) returns the controller to idle and empties the output.
module fraction_add_mul_reduce_core #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    famr_in_if.sink           i_in,
    famr_out_if.source        o_out
);

    famr_pkg::t_cmd w_cmd;
    famr_pkg::t_sts w_sts;

    famr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    famr_dp #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_mode      (i_in.mode),
        .i_a_num     (i_in.a_num),
        .i_a_den     (i_in.a_den),
        .i_b_num     (i_in.b_num),
        .i_b_den     (i_in.b_den),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_status    (o_out.status),
        .o_res_num   (o_out.res_num),
        .o_res_den   (o_out.res_den)
    );

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int OPW = 16;
    localparam int DIR_N = 22;
    localparam int RAND_PER_PHASE = 150;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 200;

    localparam logic OP_ADD = 1'b0;
    localparam logic OP_MUL = 1'b1;

    typedef struct packed {
        logic                  mode;
        logic signed [OPW-1:0] a_num;
        logic signed [OPW-1:0] a_den;
        logic signed [OPW-1:0] b_num;
        logic signed [OPW-1:0] b_den;
    } t_operands;

    typedef struct {
        famr_pkg::t_status                      status;
        logic signed [famr_pkg::NUM_OUT_W-1:0]  num;
        logic signed [famr_pkg::DEN_OUT_W-1:0]  den;
    } t_fraction;

    typedef struct {
        logic              mode;
        int                a_num;
        int                a_den;
        int                b_num;
        int                b_den;
        bit                typed;
        famr_pkg::t_status status;
        longint            num;
        longint            den;
    } t_case;

    logic clk;
    logic rst_n;

    famr_in_if #(.W(OPW)) in_if ();
    famr_out_if           out_if ();

    fraction_add_mul_reduce_core #(
        .OPERAND_WIDTH(OPW)
    ) u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_fraction reduced_q[$];

    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int n_errors = 0;
    int n_words = 0;
    int n_mul = 0;
    int n_status [3] = '{0, 0, 0};
    int stall_cycles = 0;

    t_case dir_table [DIR_N] = '{
        '{OP_ADD, 1, 2, 1, 3, 1'b1, famr_pkg::ST_OK, 5, 6},
        '{OP_ADD, 1, 0, 1, 1, 1'b1, famr_pkg::ST_DEN_ZERO, 0, 0},
        '{OP_MUL, 3, 4, 5, 0, 1'b1, famr_pkg::ST_DEN_ZERO, 0, 0},
        '{OP_MUL, 0, 0, 0, 0, 1'b1, famr_pkg::ST_DEN_ZERO, 0, 0},
        '{OP_MUL, 0, 5, 7, 3, 1'b1, famr_pkg::ST_NUM_ZERO, 0, 1},
        '{OP_ADD, 1, 2, -1, 2, 1'b1, famr_pkg::ST_NUM_ZERO, 0, 1},
        '{OP_ADD, -32768, -32768, -32768, -32768, 1'b1, famr_pkg::ST_OK, 2, 1},
        '{OP_MUL, -32768, 32767, -32768, 32767, 1'b1, famr_pkg::ST_OK, 1073741824, 1073676289},
        '{OP_MUL, 32767, -32768, 32767, 1, 1'b1, famr_pkg::ST_OK, 1073676289, -32768},
        '{OP_ADD, 32767, 1, 32767, 1, 1'b1, famr_pkg::ST_OK, 65534, 1},
        '{OP_MUL, -1, 1, 1, -1, 1'b1, famr_pkg::ST_OK, -1, -1},
        '{OP_ADD, -32768, 32767, -32768, 32767, 1'b1, famr_pkg::ST_OK, -65536, 32767},
        '{OP_ADD, 0, -32768, 0, -32768, 1'b1, famr_pkg::ST_NUM_ZERO, 0, 1},
        '{OP_ADD, 6, 4, 10, -6, 1'b0, famr_pkg::ST_OK, 0, 0},
        '{OP_MUL, 12, 18, -9, 8, 1'b0, famr_pkg::ST_OK, 0, 0},
        '{OP_ADD, 100, -200, 7, 3, 1'b0, famr_pkg::ST_OK, 0, 0},
        '{OP_MUL, -1, -1, -1, -1, 1'b0, famr_pkg::ST_OK, 0, 0},
        '{OP_ADD, 21845, -21846, 21845, -21846, 1'b0, famr_pkg::ST_OK, 0, 0},
        '{OP_MUL, 30030, 4620, -2310, 9009, 1'b0, famr_pkg::ST_OK, 0, 0},
        '{OP_ADD, 7, -3, -5, 3, 1'b0, famr_pkg::ST_OK, 0, 0},
        '{OP_MUL, 5, 0, 0, 7, 1'b0, famr_pkg::ST_OK, 0, 0},
        '{OP_ADD, 1, -32768, 1, -32768, 1'b0, famr_pkg::ST_OK, 0, 0}
    };

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic t_fraction reduce_fraction(input t_operands w);
        longint    an, ad, bn, bd, num, den, x, y, t;
        t_fraction r;
        an = $signed(w.a_num);
        ad = $signed(w.a_den);
        bn = $signed(w.b_num);
        bd = $signed(w.b_den);
        num = (w.mode == OP_MUL) ? an * bn : an * bd + bn * ad;
        den = ad * bd;
        if (den == 0) begin
            r = '{famr_pkg::ST_DEN_ZERO, '0, '0};
        end else if (num == 0) begin
            r = '{famr_pkg::ST_NUM_ZERO, '0, famr_pkg::DEN_OUT_W'(1)};
        end else begin
            x = (num < 0) ? -num : num;
            y = (den < 0) ? -den : den;
            while (y != 0) begin
                t = x % y;
                x = y;
                y = t;
            end
            r = '{famr_pkg::ST_OK, famr_pkg::NUM_OUT_W'(num / x),
                  famr_pkg::DEN_OUT_W'(den / x)};
        end
        return r;
    endfunction

    function automatic logic signed [OPW-1:0] small_operand();
        return OPW'(int'($urandom_range(80)) - 40);
    endfunction

    function automatic t_operands random_operands();
        t_operands w;
        int        kind;
        int        corner_vals [6] = '{-32768, -32767, -1, 0, 1, 32767};
        w.mode  = 1'($urandom_range(1));
        w.a_num = OPW'($urandom);
        w.a_den = OPW'($urandom);
        w.b_num = OPW'($urandom);
        w.b_den = OPW'($urandom);
        kind = $urandom_range(99);
        if (kind < 25) begin
            w.a_num = small_operand();
            w.a_den = small_operand();
            w.b_num = small_operand();
            w.b_den = small_operand();
        end else if (kind < 33) begin
            if ($urandom_range(1) == 0)
                w.a_den = '0;
            else
                w.b_den = '0;
        end else if (kind < 41) begin
            if (w.mode == OP_MUL) begin
                if ($urandom_range(1) == 0)
                    w.a_num = '0;
                else
                    w.b_num = '0;
            end else begin
                w.b_num = -w.a_num;
                w.b_den = w.a_den;
            end
        end else if (kind < 48) begin
            w.a_num = OPW'(corner_vals[$urandom_range(5)]);
            w.a_den = OPW'(corner_vals[$urandom_range(5)]);
            w.b_num = OPW'(corner_vals[$urandom_range(5)]);
            w.b_den = OPW'(corner_vals[$urandom_range(5)]);
        end
        return w;
    endfunction

    task automatic send_word(input t_operands w, input t_fraction predicted);
        while ($urandom_range(99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge clk);
        end
        in_if.valid <= 1'b1;
        in_if.mode  <= w.mode;
        in_if.a_num <= w.a_num;
        in_if.a_den <= w.a_den;
        in_if.b_num <= w.b_num;
        in_if.b_den <= w.b_den;
        do @(posedge clk); while (!in_if.ready);
        reduced_q.push_back(predicted);
        n_words++;
        if (w.mode == OP_MUL)
            n_mul++;
        n_status[predicted.status]++;
    endtask

    // hold valid low until every pending result has drained
    task automatic hold_until_drained();
        in_if.valid <= 1'b0;
        do @(posedge clk); while (reduced_q.size() != 0);
    endtask

    always @(posedge clk) begin
        out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge clk) begin
        t_fraction want;
        if (rst_n && out_if.valid && out_if.ready) begin
            if (reduced_q.size() == 0) begin
                $error("result word with nothing pending: status %0d num %0d den %0d",
                       out_if.status, out_if.res_num, out_if.res_den);
                n_errors++;
            end else begin
                want = reduced_q.pop_front();
                if (out_if.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, out_if.status);
                    n_errors++;
                end
                if (out_if.res_num !== want.num) begin
                    $error("res_num: expected %0d, got %0d", want.num, out_if.res_num);
                    n_errors++;
                end
                if (out_if.res_den !== want.den) begin
                    $error("res_den: expected %0d, got %0d", want.den, out_if.res_den);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $error("no word moved for %0d cycles", STALL_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        t_operands w;
        t_fraction predicted;
        clk = 1'b0;
        rst_n        <= 1'b0;
        in_if.valid  <= 1'b0;
        in_if.mode   <= OP_ADD;
        in_if.a_num  <= '0;
        in_if.a_den  <= '0;
        in_if.b_num  <= '0;
        in_if.b_den  <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_table[i]) begin
            w.mode  = dir_table[i].mode;
            w.a_num = OPW'(dir_table[i].a_num);
            w.a_den = OPW'(dir_table[i].a_den);
            w.b_num = OPW'(dir_table[i].b_num);
            w.b_den = OPW'(dir_table[i].b_den);
            if (dir_table[i].typed)
                predicted = '{dir_table[i].status,
                              famr_pkg::NUM_OUT_W'(dir_table[i].num),
                              famr_pkg::DEN_OUT_W'(dir_table[i].den)};
            else
                predicted = reduce_fraction(w);
            send_word(w, predicted);
        end
        hold_until_drained();

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    src_idle_pct = 24;
                    snk_idle_pct = 46;
                end
                1: begin
                    src_idle_pct = 46;
                    snk_idle_pct = 24;
                end
                default: begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
            endcase
            repeat (RAND_PER_PHASE) begin
                w = random_operands();
                send_word(w, reduce_fraction(w));
            end
            hold_until_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d fraction pairs (%0d multiply, %0d add) under three stall patterns,",
                 n_words, n_mul, n_words - n_mul);
        $display("covering %0d reduced, %0d zero-denominator and %0d zero-numerator results.",
                 n_status[famr_pkg::ST_OK], n_status[famr_pkg::ST_DEN_ZERO],
                 n_status[famr_pkg::ST_NUM_ZERO]);
        if (n_errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
